// File: sv/scm_pkg.sv
`default_nettype none

package scm_pkg;

    // Field widths of the stream items.
    localparam int OPCODE_W   = 3;
    localparam int CHAN_W     = 4;
    localparam int INDEX_W    = 4;
    localparam int SUM_W      = 20;
    localparam int STEP_OUT_W = 4;
    localparam int CFG_W      = 5;
    localparam int M_DATA_W   = 32;

    localparam logic [CFG_W-1:0] STEP_COUNT_RESET = 5'd2;

    localparam int SUM_MAX = 524287;
    localparam int SUM_MIN = -524288;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE   = 3'd0,
        OP_TOGGLE   = 3'd1,
        OP_ADVANCE  = 3'd2,
        OP_EDIT_NXT = 3'd3,
        OP_EDIT_PRV = 3'd4,
        OP_SET_COL  = 3'd5
    } opcode_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic hold_write;
        logic acc_clear;
        logic sum_step;
        logic rd_edit;
        logic wr_toggle;
        logic rd_set;
        logic wr_set;
        logic out_load;
        logic mod_start;
        logic mod_step;
        logic edit_inc;
        logic edit_dec;
    } cmd_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic clr_last;
        logic row_last;
        logic edit_ok;
        logic out_last;
        logic mod_last;
    } status_t;

endpackage

`default_nettype wire

// File: sv/scm_ctrl.sv
`default_nettype none

module scm_ctrl
    import scm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire logic                frame_end,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output cmd_t                     cmd,
    input  wire status_t             st
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_SUM_END,
        ST_OUT_LOAD,
        ST_EMIT,
        ST_TOG_RD,
        ST_TOG_WR,
        ST_SET_RD,
        ST_SET_WR,
        ST_MOD
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (st.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    case (opcode_t'(opcode))
                        OP_SAMPLE: begin
                            cmd.hold_write = 1'b1;
                            if (frame_end) begin
                                cmd.acc_clear = 1'b1;
                                state_next    = ST_SUM;
                            end
                        end
                        OP_TOGGLE:   state_next = ST_TOG_RD;
                        OP_ADVANCE: begin
                            cmd.mod_start = 1'b1;
                            state_next    = ST_MOD;
                        end
                        OP_EDIT_NXT: cmd.edit_inc = 1'b1;
                        OP_EDIT_PRV: cmd.edit_dec = 1'b1;
                        OP_SET_COL:  state_next = ST_SET_RD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (st.row_last) begin
                    state_next = ST_SUM_END;
                end
            end
            ST_SUM_END: state_next = ST_OUT_LOAD;
            ST_OUT_LOAD: begin
                cmd.out_load = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (st.out_last) begin
                        m_valid_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        cmd.out_load = 1'b1;
                    end
                end
            end
            ST_TOG_RD: begin
                if (st.edit_ok) begin
                    cmd.rd_edit = 1'b1;
                    state_next  = ST_TOG_WR;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TOG_WR: begin
                cmd.wr_toggle = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SET_RD: begin
                if (st.edit_ok) begin
                    cmd.rd_set = 1'b1;
                    state_next = ST_SET_WR;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SET_WR: begin
                cmd.wr_set = 1'b1;
                state_next = st.row_last ? ST_IDLE : ST_SET_RD;
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (st.mod_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/scm_datapath.sv
`default_nettype none

module scm_datapath
    import scm_pkg::*;
#(
    parameter int STEPS       = 16,
    parameter int CHANNELS    = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cmd_t                          cmd,
    output status_t                            st,
    input  wire logic [CHAN_W-1:0]             ch_in,
    input  wire logic [CHAN_W-1:0]             col_in,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_W-1:0]              cfg_wr_data,
    output logic [INDEX_W-1:0]                 out_index,
    output logic signed [SUM_W-1:0]            out_sum,
    output logic [STEP_OUT_W-1:0]              out_step
);

    localparam int STEP_W    = $clog2(STEPS);
    localparam int ROW_W     = $clog2(CHANNELS);
    localparam int ADDR_W    = STEP_W + ROW_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int ACC_W     = SAMPLE_BITS + ROW_W;
    localparam int SAT_W     = (ACC_W > SUM_W) ? ACC_W : SUM_W;
    localparam int RW        = STEP_W + 1;
    localparam int CW        = (CFG_W > RW) ? CFG_W : RW;
    localparam int DW        = 2 * STEP_W + 1;
    localparam int SH_W      = $clog2(STEP_W + 1);

    // Routing store: one row per step and input, one bit per output.
    logic [CHANNELS-1:0] route_mem [MEM_DEPTH];
    logic [CHANNELS-1:0] rd_reg;

    logic signed [SAMPLE_BITS-1:0] held_reg [CHANNELS];
    logic signed [ACC_W-1:0]       acc_reg  [CHANNELS];

    logic [CFG_W-1:0]  step_count_reg;
    logic [STEP_W-1:0] play_reg, edit_reg;
    logic [CHAN_W-1:0] ch_reg, col_reg;
    logic [ROW_W-1:0]  row_cnt_reg, col_cnt_reg, acc_row_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              acc_en_reg;
    logic              out_last_reg;
    logic [RW-1:0]     rem_reg;
    logic [SH_W-1:0]   sh_reg;

    logic [INDEX_W-1:0]      out_index_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic [STEP_OUT_W-1:0]   out_step_reg;

    logic [ROW_W-1:0]    ch_row, col_row, in_row;
    logic [CHANNELS-1:0] col_hot;
    logic                in_ch_ok;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_wa, mem_ra;
    logic [CHANNELS-1:0] mem_wd;

    assign ch_row   = ch_reg[ROW_W-1:0];
    assign col_row  = col_reg[ROW_W-1:0];
    assign in_row   = ch_in[ROW_W-1:0];
    assign in_ch_ok = ({1'b0, ch_in} < (CHAN_W + 1)'(CHANNELS));
    assign col_hot  = {{(CHANNELS - 1){1'b0}}, 1'b1} << col_row;

    assign st.clr_last = (clr_cnt_reg == {ADDR_W{1'b1}});
    assign st.row_last = (row_cnt_reg == ROW_W'(CHANNELS - 1));
    assign st.edit_ok  = ({1'b0, ch_reg} < (CHAN_W + 1)'(CHANNELS)) &&
                         ({1'b0, col_reg} < (CHAN_W + 1)'(CHANNELS));
    assign st.out_last = out_last_reg;
    assign st.mod_last = (sh_reg == '0);

    assign out_index = out_index_reg;
    assign out_sum   = out_sum_reg;
    assign out_step  = out_step_reg;

    // Memory port selection.
    always_comb begin
        mem_we = cmd.clr_step || cmd.wr_toggle || cmd.wr_set;
        mem_re = cmd.sum_step || cmd.rd_edit || cmd.rd_set;
        if (cmd.clr_step) begin
            mem_wa = clr_cnt_reg;
            mem_wd = '0;
        end else if (cmd.wr_toggle) begin
            mem_wa = {edit_reg, ch_row};
            mem_wd = rd_reg ^ col_hot;
        end else begin
            mem_wa = {edit_reg, row_cnt_reg};
            mem_wd = (rd_reg & ~col_hot) | ((row_cnt_reg == ch_row) ? col_hot : '0);
        end
        if (cmd.sum_step) begin
            mem_ra = {play_reg, row_cnt_reg};
        end else if (cmd.rd_edit) begin
            mem_ra = {edit_reg, ch_row};
        end else begin
            mem_ra = {edit_reg, row_cnt_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            route_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_reg <= route_mem[mem_ra];
        end
    end

    // Playing step length, held inside 1..STEPS.
    logic [CW-1:0] sc_x;
    logic [RW-1:0] step_len;

    always_comb begin
        sc_x = CW'(step_count_reg);
        if (sc_x == '0) begin
            step_len = RW'(1);
        end else if (sc_x > CW'(STEPS)) begin
            step_len = RW'(STEPS);
        end else begin
            step_len = RW'(sc_x);
        end
    end

    // One restoring remainder step per cycle.
    logic [DW-1:0] div_shift, rem_x, rem_sub;
    logic [RW-1:0] rem_next;

    always_comb begin
        div_shift = DW'(step_len) << sh_reg;
        rem_x     = DW'(rem_reg);
        rem_sub   = rem_x - div_shift;
        rem_next  = (rem_x >= div_shift) ? rem_sub[RW-1:0] : rem_reg;
    end

    // Saturation of the selected lane for the output register.
    logic signed [SAT_W-1:0] acc_x, sat_x;
    logic [31:0]             col_ext, play_ext;

    always_comb begin
        acc_x = SAT_W'(acc_reg[col_cnt_reg]);
        if (acc_x > SAT_W'(SUM_MAX)) begin
            sat_x = SAT_W'(SUM_MAX);
        end else if (acc_x < SAT_W'(SUM_MIN)) begin
            sat_x = SAT_W'(SUM_MIN);
        end else begin
            sat_x = acc_x;
        end
        col_ext  = 32'(col_cnt_reg);
        play_ext = 32'(play_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= STEP_COUNT_RESET;
            play_reg       <= '0;
            edit_reg       <= '0;
            clr_cnt_reg    <= '0;
            acc_en_reg     <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                held_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                step_count_reg <= cfg_wr_data;
            end
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.hold_write && in_ch_ok) begin
                held_reg[in_row] <= sample_in;
            end
            if (cmd.edit_inc) begin
                edit_reg <= (edit_reg == STEP_W'(STEPS - 1)) ? '0 : edit_reg + 1'b1;
            end else if (cmd.edit_dec) begin
                edit_reg <= (edit_reg == '0) ? STEP_W'(STEPS - 1) : edit_reg - 1'b1;
            end
            if (cmd.mod_step && st.mod_last) begin
                play_reg <= rem_next[STEP_W-1:0];
            end
            acc_en_reg <= cmd.sum_step;
        end
    end

    // Payload and counters that need no reset.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg      <= ch_in;
            col_reg     <= col_in;
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else if (cmd.sum_step || cmd.wr_set) begin
            row_cnt_reg <= row_cnt_reg + 1'b1;
        end else if (cmd.out_load) begin
            col_cnt_reg <= col_cnt_reg + 1'b1;
        end
        acc_row_reg <= row_cnt_reg;
        if (cmd.acc_clear) begin
            for (int c = 0; c < CHANNELS; c++) begin
                acc_reg[c] <= '0;
            end
        end else if (acc_en_reg) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (rd_reg[c]) begin
                    acc_reg[c] <= acc_reg[c] + ACC_W'(held_reg[acc_row_reg]);
                end
            end
        end
        if (cmd.out_load) begin
            out_sum_reg   <= SUM_W'(sat_x);
            out_index_reg <= col_ext[INDEX_W-1:0];
            out_step_reg  <= play_ext[STEP_OUT_W-1:0];
            out_last_reg  <= (col_cnt_reg == ROW_W'(CHANNELS - 1));
        end
        if (cmd.mod_start) begin
            rem_reg <= RW'(play_reg) + 1'b1;
            sh_reg  <= SH_W'(STEP_W);
        end else if (cmd.mod_step) begin
            rem_reg <= rem_next;
            sh_reg  <= sh_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: sv/stepped_crosspoint_mixer_core.sv
`default_nettype none

// Stepped crosspoint mixer: CHANNELS inputs by CHANNELS outputs with on/off
// crosspoints, holding STEPS routing matrices. The slave stream carries one
// item per transfer; the opcode in s_tuser selects a sample load, a crosspoint
// toggle, a playing step advance, an edit step move or a one-hot column set.
// A sample transfer with s_tlast high loads the sample and then produces
// CHANNELS master transfers, one sum per output in order, with m_tlast on the
// final one. The block takes one item at a time. For a frame end the routing
// rows of the playing step are read from the store one per cycle into
// CHANNELS parallel accumulators, then one sum per cycle goes out as the
// master side takes them. A toggle reads and rewrites one row; a column set
// reads and writes each row through the one store port pair, and an advance
// runs in the bit-serial remainder unit. After reset a clearing pass zeroes the
// routing store, one row per cycle, all 2**(clog2(STEPS) + clog2(CHANNELS)) rows
// (256 at the default sizes); s_tready stays low until it finishes. The step
// count register may be written at any time the block is idle.
module stepped_crosspoint_mixer_core
    import scm_pkg::*;
#(
    parameter int STEPS       = 16,
    parameter int CHANNELS    = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    // Step count register.
    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_W-1:0]    cfg_wr_data,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // Fields from bit 0 up: channel, output_column, sample, zero padding.
    input  wire logic [((2 * CHAN_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // Fields from bit 0 up: opcode.
    input  wire logic [OPCODE_W-1:0] s_tuser,
    input  wire logic                s_tlast,

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // Fields from bit 0 up: output_index, mix_sum, playing_step, zero padding.
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tlast
);

    localparam int M_PAD = M_DATA_W - (INDEX_W + SUM_W + STEP_OUT_W);

    cmd_t    cmd;
    status_t st;

    logic [INDEX_W-1:0]      out_index;
    logic signed [SUM_W-1:0] out_sum;
    logic [STEP_OUT_W-1:0]   out_step;

    // The sequencer decides what each accepted transfer does and paces the
    // datapath through the store reads and writes that follow.
    scm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .opcode    (s_tuser),
        .frame_end (s_tlast),
        .s_ready   (s_tready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .cmd       (cmd),
        .st        (st)
    );

    // The datapath holds the routing store, the held samples, the step
    // counters and the output register that drives m_tdata.
    scm_datapath #(
        .STEPS       (STEPS),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .st          (st),
        .ch_in       (s_tdata[CHAN_W-1:0]),
        .col_in      (s_tdata[2*CHAN_W-1:CHAN_W]),
        .sample_in   (s_tdata[2*CHAN_W +: SAMPLE_BITS]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_index   (out_index),
        .out_sum     (out_sum),
        .out_step    (out_step)
    );

    assign m_tdata = {{M_PAD{1'b0}}, out_step, out_sum, out_index};
    assign m_tlast = st.out_last;

endmodule

`default_nettype wire

// File: tb/sv/tb_stepped_crosspoint_mixer_core.sv
`timescale 1ns / 100ps

module tb_stepped_crosspoint_mixer_core;
    import scm_pkg::*;

    // Sizes of the block under test; they match its default parameters.
    localparam int N_STEPS     = 16;
    localparam int N_CHANNELS  = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int S_DATA_W    = ((2 * CHAN_W + SAMPLE_BITS + 7) / 8) * 8;

    // The opcode field has two codes that the package does not name. The block
    // must swallow both without touching its state or producing a sum.
    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    // Cycles to let pass after the last sum before a register write. The
    // slowest item without a result is a column set, which reads and writes each row.
    localparam int SETTLE_CYCLES = 40;
    // Length of the long receiver hold that fills the block up.
    localparam int HOLD_CYCLES   = 300;
    // Hard stop for the whole run, far above the slowest correct run.
    localparam int RUN_LIMIT_NS  = 3_200_000;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]        cfg_wr_data = '0;
    logic                    s_tvalid    = 1'b0;
    logic                    s_tready;
    logic [S_DATA_W-1:0]     s_tdata     = '0;
    logic [OPCODE_W-1:0]     s_tuser     = '0;
    logic                    s_tlast     = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready    = 1'b0;
    logic [M_DATA_W-1:0]     m_tdata;
    logic                    m_tlast;

    // One expected output sum of a frame.
    typedef struct {
        logic [INDEX_W-1:0]       index;
        logic signed [SUM_W-1:0]  sum;
        logic [STEP_OUT_W-1:0]    step;
        logic                     last;
    } sum_entry_t;

    // The scoreboard keeps its own copy of the mixer: the routing matrices of
    // every step, the held samples and the two step pointers. Each accepted
    // input transfer updates that copy, and a frame end pushes the ten sums the
    // block has to produce in output order.
    class mix_scoreboard;
        logic [N_CHANNELS-1:0]   routes [N_STEPS][N_CHANNELS];
        logic signed [15:0]      held [N_CHANNELS];
        logic [3:0]              play_step;
        logic [3:0]              edit_step;
        logic [CFG_W-1:0]        step_count;
        sum_entry_t              pending_sums [$];
        int                      errors;
        int                      checked;
        int                      frames;

        function new();
            foreach (routes[s, r]) routes[s][r] = '0;
            foreach (held[r]) held[r] = '0;
            play_step  = '0;
            edit_step  = '0;
            step_count = STEP_COUNT_RESET;
            errors     = 0;
            checked    = 0;
            frames     = 0;
        endfunction

        function void set_step_count(logic [CFG_W-1:0] value);
            step_count = value;
        endfunction

        function void note_input(logic [OPCODE_W-1:0] op, logic [3:0] ch, logic [3:0] col,
                                 logic [15:0] smp, logic fe);
            int         acc;
            int         span;
            sum_entry_t entry;
            case (op)
                OP_SAMPLE: begin
                    if (ch < N_CHANNELS) held[ch] = smp;
                    if (fe) begin
                        for (int c = 0; c < N_CHANNELS; c++) begin
                            acc = 0;
                            for (int r = 0; r < N_CHANNELS; r++)
                                if (routes[play_step][r][c]) acc += int'(held[r]);
                            if (acc > SUM_MAX) acc = SUM_MAX;
                            if (acc < SUM_MIN) acc = SUM_MIN;
                            entry.index = c[3:0];
                            entry.sum   = acc[SUM_W-1:0];
                            entry.step  = play_step;
                            entry.last  = (c == N_CHANNELS - 1);
                            pending_sums.push_back(entry);
                        end
                    end
                end
                OP_TOGGLE: begin
                    if (ch < N_CHANNELS && col < N_CHANNELS)
                        routes[edit_step][ch][col] = ~routes[edit_step][ch][col];
                end
                OP_ADVANCE: begin
                    // Out-of-range counts are clamped only when the step moves.
                    span = step_count;
                    if (span < 1) span = 1;
                    if (span > N_STEPS) span = N_STEPS;
                    play_step = 4'((int'(play_step) + 1) % span);
                end
                OP_EDIT_NXT: edit_step = 4'((int'(edit_step) + 1) % N_STEPS);
                OP_EDIT_PRV: edit_step = 4'((int'(edit_step) + N_STEPS - 1) % N_STEPS);
                OP_SET_COL: begin
                    if (ch < N_CHANNELS && col < N_CHANNELS)
                        for (int r = 0; r < N_CHANNELS; r++)
                            routes[edit_step][r][col] = (r == ch);
                end
                default: ;
            endcase
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 30) $display("MISMATCH at %0t ns: %s", $realtime, msg);
        endtask

        task check_result(logic [INDEX_W-1:0] index, logic signed [SUM_W-1:0] sum,
                          logic [STEP_OUT_W-1:0] step, logic last);
            sum_entry_t want;
            checked++;
            if (pending_sums.size() == 0) begin
                report($sformatf("unexpected sum for output %0d", index));
            end else begin
                want = pending_sums.pop_front();
                if (index !== want.index)
                    report($sformatf("output index %0d, wanted %0d", index, want.index));
                if (sum !== want.sum)
                    report($sformatf("output %0d sum %0d, wanted %0d",
                                     want.index, sum, want.sum));
                if (step !== want.step)
                    report($sformatf("output %0d playing step %0d, wanted %0d",
                                     want.index, step, want.step));
                if (last !== want.last)
                    report($sformatf("output %0d last flag %0b, wanted %0b",
                                     want.index, last, want.last));
                if (want.last) frames++;
            end
        endtask

        task drain_leftovers();
            sum_entry_t left;
            while (pending_sums.size() != 0) begin
                left = pending_sums.pop_front();
                report($sformatf("sum for output %0d never arrived", left.index));
            end
        endtask
    endclass

    mix_scoreboard sb = new();

    // Percentage of cycles in which each side idles; the main sequence sets it
    // per phase so that one phase runs with no idling at all.
    int  idle_pct      = 16;
    // Set by the main sequence, cleared by the receiver once its hold is over.
    bit  hold_request  = 1'b0;
    int  op_seen [8];
    int  settings_used = 1;

    stepped_crosspoint_mixer_core #(
        .STEPS       (N_STEPS),
        .CHANNELS    (N_CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #4 aclk = ~aclk;

    // Offers one item and waits for its transfer. A random gap may come first.
    // The valid is not lowered after the transfer: either the next call raises
    // it again in the following step or the caller drops it, so each step sees
    // at most one assignment to it. Signals are read right after the edge,
    // before the block's own updates of that edge take effect.
    task send_item(logic [OPCODE_W-1:0] op, logic [3:0] ch, logic [3:0] col,
                   logic [15:0] smp, logic fe);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {smp, col, ch};
        s_tlast  <= fe;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, ch, col, smp, fe);
        op_seen[op]++;
    endtask

    // One random item. Most items are samples and routing edits so that the
    // matrices fill up and the sums draw on many inputs; a small share carries
    // out-of-range channels or columns and the two unused opcodes.
    task send_random_item();
        int                  pick;
        logic [OPCODE_W-1:0] op;
        logic [3:0]          ch;
        logic [3:0]          col;
        logic [15:0]         smp;
        logic                fe;
        pick = $urandom_range(99);
        fe   = 1'($urandom_range(1));
        if (pick < 30) begin
            op = OP_SAMPLE;
            fe = 1'b0;
        end else if (pick < 45) begin
            op = OP_SAMPLE;
            fe = 1'b1;
        end else if (pick < 62) op = OP_TOGGLE;
        else if (pick < 72) op = OP_SET_COL;
        else if (pick < 82) op = OP_ADVANCE;
        else if (pick < 88) op = OP_EDIT_NXT;
        else if (pick < 94) op = OP_EDIT_PRV;
        else if (pick < 97) op = OP_SPARE_6;
        else op = OP_SPARE_7;
        ch  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
        col = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
        case ($urandom_range(7))
            0: smp = 16'h7FFF;
            1: smp = 16'h8000;
            2: smp = 16'hFFFF;
            default: smp = 16'($urandom);
        endcase
        send_item(op, ch, col, smp, fe);
    endtask

    // Register writes happen only with the block idle: the valid is dropped,
    // every expected sum has come out, and the slowest silent item has had
    // time to finish before the write.
    task write_step_count(logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_step_count(value);
        settings_used++;
    endtask

    // Receiver side. It takes sums with random stalls and, when asked, holds
    // off for a long stretch counted here so that the block backs up.
    initial begin
        int hold_count;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready   <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(posedge aclk);
                    hold_count++;
                end
                hold_request = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Every sum transfer is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[3:0], m_tdata[23:4], m_tdata[27:24], m_tlast);
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int guard;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset step count of two. It loads the sample
        // extremes, routes them, and then walks through the cases the block
        // must ignore: out-of-range rows and columns, unused opcodes, and a
        // frame end on an event. The edit step wraps below zero and back, and
        // the playing step wraps at the step count.
        send_item(OP_SAMPLE,   4'd0,  4'd0,  16'h7FFF, 1'b0);
        send_item(OP_SAMPLE,   4'd1,  4'd0,  16'h8000, 1'b0);
        send_item(OP_SAMPLE,   4'd9,  4'd0,  16'h0001, 1'b0);
        send_item(OP_TOGGLE,   4'd0,  4'd0,  16'h0000, 1'b0);
        send_item(OP_TOGGLE,   4'd1,  4'd0,  16'h0000, 1'b1);
        send_item(OP_TOGGLE,   4'd9,  4'd9,  16'h0000, 1'b0);
        send_item(OP_SET_COL,  4'd9,  4'd5,  16'h0000, 1'b0);
        send_item(OP_SAMPLE,   4'd2,  4'd0,  16'h1234, 1'b1);
        send_item(OP_TOGGLE,   4'd10, 4'd3,  16'h0000, 1'b0);
        send_item(OP_TOGGLE,   4'd3,  4'd15, 16'h0000, 1'b0);
        send_item(OP_SET_COL,  4'd15, 4'd0,  16'h0000, 1'b0);
        send_item(OP_SET_COL,  4'd4,  4'd10, 16'h0000, 1'b0);
        send_item(OP_SAMPLE,   4'd15, 4'd15, 16'hFFFF, 1'b1);
        send_item(OP_SPARE_6,  4'd0,  4'd0,  16'h0000, 1'b1);
        send_item(OP_SPARE_7,  4'd15, 4'd15, 16'hFFFF, 1'b1);
        send_item(OP_EDIT_PRV, 4'd0,  4'd0,  16'h0000, 1'b0);
        send_item(OP_TOGGLE,   4'd3,  4'd3,  16'h0000, 1'b0);
        send_item(OP_EDIT_NXT, 4'd0,  4'd0,  16'h0000, 1'b0);
        send_item(OP_EDIT_NXT, 4'd0,  4'd0,  16'h0000, 1'b0);
        send_item(OP_SET_COL,  4'd0,  4'd0,  16'h0000, 1'b0);
        send_item(OP_ADVANCE,  4'd0,  4'd0,  16'h0000, 1'b0);
        send_item(OP_SAMPLE,   4'd0,  4'd0,  16'h8000, 1'b1);
        send_item(OP_ADVANCE,  4'd0,  4'd0,  16'h0000, 1'b0);
        send_item(OP_SAMPLE,   4'd5,  4'd0,  16'h00FF, 1'b1);

        // Random phases over several step counts: the full sixteen, a single
        // step, zero and thirty-one (both clamped by the block), a random count
        // and finally the reset value again.
        write_step_count(5'd16);
        repeat (70) send_random_item();

        write_step_count(5'd1);
        repeat (50) send_random_item();

        write_step_count(5'd0);
        repeat (40) send_random_item();

        // A stretch with no idling on either side.
        write_step_count(5'd31);
        idle_pct = 0;
        repeat (60) send_random_item();
        idle_pct = 16;

        // The receiver holds off while frame ends keep coming, so the block
        // fills with sums and has to stall its input side.
        write_step_count(5'($urandom_range(15, 3)));
        hold_request = 1'b1;
        repeat (12) send_item(OP_SAMPLE, 4'($urandom_range(9)), 4'd0, 16'($urandom), 1'b1);
        repeat (60) send_random_item();

        write_step_count(STEP_COUNT_RESET);
        repeat (100) send_random_item();

        s_tvalid <= 1'b0;
        guard = 0;
        while (sb.pending_sums.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        sb.drain_leftovers();

        $display("Run covered %0d samples, %0d routing edits, %0d step moves and %0d ignored",
                 op_seen[OP_SAMPLE], op_seen[OP_TOGGLE] + op_seen[OP_SET_COL],
                 op_seen[OP_ADVANCE] + op_seen[OP_EDIT_NXT] + op_seen[OP_EDIT_PRV],
                 op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7]);
        $display("opcodes; %0d sums in %0d frames checked over %0d step count settings.",
                 sb.checked, sb.frames, settings_used);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
